@@ sv/integer_to_decimal_ascii_unit_defines.svh @@
// Assertion macros for the decimal text formatter.
// Used by the top level only; the macros vanish when SYNTHESIS is defined.
`ifndef INTEGER_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define INTEGER_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define I2D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define I2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define I2D_ASSERT_NOW(lbl, ante, cons, msg)

`define I2D_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/i2d_pkg.sv @@
// Types and constants of the decimal text formatter.
// No dependencies; imported by every module of the block.
package i2d_pkg;

  localparam int NUM_DIGITS      = 10;
  localparam int NUM_STAGES      = 4;
  localparam int STEPS_PER_STAGE = 8;
  localparam int VALUE_W         = 32;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [3:0] DIGIT_FIVE  = 4'd5;
  localparam logic [3:0] DIGIT_THREE = 4'd3;
  localparam logic [3:0] DIGIT_NINE  = 4'd9;

  typedef logic [3:0] digit_t;

  // Request on the input channel.
  typedef struct packed {
    logic               cmd;
    logic [VALUE_W-1:0] value;
  } num_t;

  // One character on the output channel.
  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last_char;
  } char_t;

  // Working word of the shift-and-add-three conversion.
  typedef struct packed {
    logic                     neg;
    digit_t [NUM_DIGITS-1:0]  bcd;
    logic [VALUE_W-1:0]       bin;
  } word_t;

endpackage

@@ sv/i2d_if.sv @@
// Valid/ready channel carrying one request of a chosen payload type.
// Depends on nothing; the payload types come from i2d_pkg.
interface i2d_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

@@ sv/integer_to_decimal_ascii_unit.sv @@
// Decimal text formatter for 32-bit integers, signed or unsigned.
//
// Channel number takes a request {cmd, value}: cmd 0 reads value as unsigned,
// cmd 1 as two's complement. Channel text returns the decimal text one
// character per request {ascii_char, last_char}, top digit first, with a
// leading '-' for negative signed values and last_char set on the final one.
// The most negative value prints as -2147483648 and zero as a single '0'.
//
// A request passes an input register that forms sign and magnitude, then four
// conversion stages of eight shift-and-add-three steps each, then the
// serialiser. The serialiser sends one character per cycle while the receiver
// is ready; a request has 1 to 11 characters and holds it until its last one is
// taken, and the next request's first character follows directly after the last
// one of the previous request.
// The pipeline accepts a request every cycle until it holds five waiting ones.
// Reset clears all valid bits; no characters are pending after it.
// When the receiver stalls, the shown character holds and the pipeline fills
// and then drops number.ready; nothing is lost or repeated.
// Depends on i2d_pkg, i2d_if, i2d_stage, i2d_serial and the defines header.
`include "integer_to_decimal_ascii_unit_defines.svh"

module integer_to_decimal_ascii_unit (
  input logic clk,
  input logic rst,
  i2d_if.sink   number,
  i2d_if.source text
);
  import i2d_pkg::*;

  i2d_if #(.payload_t(word_t)) stage_ch [NUM_STAGES+1] ();

  logic               in_neg;
  logic               bcd_ok;
  logic [VALUE_W-1:0] in_mag;
  logic               in_take;
  logic               sign_shown;
  logic               sign_taken;
  logic               digit_shown;

  // Sign and magnitude; the magnitude of the most negative value wraps to itself,
  // which is the correct unsigned magnitude.
  assign in_neg = number.payload.cmd && number.payload.value[VALUE_W-1];
  assign in_mag = in_neg ? (~number.payload.value + VALUE_W'(1)) : number.payload.value;

  assign number.ready = !stage_ch[0].valid || stage_ch[0].ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_ch[0].valid <= 1'b0;
    end else if (number.ready) begin
      stage_ch[0].valid <= number.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (number.valid && number.ready) begin
      stage_ch[0].payload.neg <= in_neg;
      stage_ch[0].payload.bcd <= '0;
      stage_ch[0].payload.bin <= in_mag;
    end
  end

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    i2d_stage u_stage (
      .clk  (clk),
      .rst  (rst),
      .up   (stage_ch[g]),
      .down (stage_ch[g+1])
    );
  end

  i2d_serial u_serial (
    .clk    (clk),
    .rst    (rst),
    .bcd_in (stage_ch[NUM_STAGES]),
    .text   (text)
  );

  always_comb begin
    bcd_ok = 1'b1;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (stage_ch[NUM_STAGES].payload.bcd[d] > DIGIT_NINE) begin
        bcd_ok = 1'b0;
      end
    end
  end

  assign in_take     = number.valid && number.ready;
  assign sign_shown  = text.valid && (text.payload.ascii_char == CHAR_MINUS);
  assign sign_taken  = sign_shown && text.ready;
  assign digit_shown = text.valid && (text.payload.ascii_char != CHAR_MINUS);

  `I2D_ASSERT_NEXT(a_accept_fills_front, in_take, stage_ch[0].valid, "request not registered")
  `I2D_ASSERT_NOW(a_bcd_digits_valid, stage_ch[NUM_STAGES].valid, bcd_ok, "digit above nine")
  `I2D_ASSERT_NEXT(a_digit_after_sign, sign_taken, digit_shown, "sign not followed by digit")
  `I2D_ASSERT_NOW(a_sign_not_last, sign_shown, !text.payload.last_char, "sign flagged last")

endmodule

@@ sv/i2d_stage.sv @@
// One pipeline stage of the binary to BCD conversion: eight shift-and-add-three steps.
// Depends on i2d_pkg and i2d_if.
module i2d_stage (
  input logic clk,
  input logic rst,
  i2d_if.sink   up,
  i2d_if.source down
);
  import i2d_pkg::*;

  word_t w;

  always_comb begin
    w = up.payload;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (w.bcd[d] >= DIGIT_FIVE) begin
          w.bcd[d] = w.bcd[d] + DIGIT_THREE;
        end
      end
      {w.bcd, w.bin} = {w.bcd, w.bin} << 1;
    end
  end

  assign up.ready = !down.valid || down.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down.valid <= 1'b0;
    end else if (up.ready) begin
      down.valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      down.payload <= w;
    end
  end

endmodule

@@ sv/i2d_serial.sv @@
// Character serialiser: emits the sign and the significant BCD digits, top digit first.
// Depends on i2d_pkg and i2d_if.
module i2d_serial (
  input logic clk,
  input logic rst,
  i2d_if.sink   bcd_in,
  i2d_if.source text
);
  import i2d_pkg::*;

  logic                    busy;
  logic                    neg_pend;
  logic [3:0]              idx;
  digit_t [NUM_DIGITS-1:0] digits;
  logic [3:0]              top_idx;
  logic                    out_last;

  // Position of the highest non-zero digit; zero gives position 0.
  always_comb begin
    top_idx = '0;
    for (int d = 1; d < NUM_DIGITS; d++) begin
      if (bcd_in.payload.bcd[d] != '0) begin
        top_idx = 4'(d);
      end
    end
  end

  assign out_last                = !neg_pend && (idx == '0);
  assign text.valid              = busy;
  assign text.payload.ascii_char = neg_pend ? CHAR_MINUS : (CHAR_ZERO + {4'b0, digits[idx]});
  assign text.payload.last_char  = out_last;

  // A new request loads as the final character of the previous one leaves.
  assign bcd_in.ready = !busy || (text.ready && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      neg_pend <= 1'b0;
      idx      <= '0;
    end else if (bcd_in.valid && bcd_in.ready) begin
      busy     <= 1'b1;
      neg_pend <= bcd_in.payload.neg;
      idx      <= top_idx;
    end else if (busy && text.ready) begin
      if (neg_pend) begin
        neg_pend <= 1'b0;
      end else if (idx == '0) begin
        busy <= 1'b0;
      end else begin
        idx <= idx - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bcd_in.valid && bcd_in.ready) begin
      digits <= bcd_in.payload.bcd;
    end
  end

endmodule
